// File: src/nvdq_pkg.sv
// Package for the NVFP4 to bfloat16 dequantizer: commands, fp32 constants,
// and the multiplier front-end struct with fp32 helper functions. No dependencies.
`default_nettype none
package nvdq_pkg;
    localparam logic [1:0] CMD_CONVERT    = 2'd0;
    localparam logic [1:0] CMD_LOAD_CODE  = 2'd1;
    localparam logic [1:0] CMD_LOAD_SCALE = 2'd2;

    localparam logic [31:0] FP_ABS_MASK = 32'h7fffffff;
    localparam logic [31:0] FP_INF      = 32'h7f800000;
    localparam logic [31:0] FP_QNAN     = 32'h7fc00000;
    localparam logic [31:0] FP_QUIET    = 32'h00400000;
    localparam logic [15:0] BF_QUIET    = 16'h0040;
    localparam logic [31:0] BF_BIAS     = 32'h00007fff;

    // Multiplier front-end result handed to the rounding stage
    typedef struct packed {
        logic        special;   // result fully decided in front end
        logic [31:0] spec_val;
        logic        sign;
        logic [9:0]  exp;       // signed biased exponent of product
        logic [47:0] prod;      // normalized, bit 47 set
    } mul_mid_t;

    // Count leading zeros of a 24-bit significand (at most 23 for nonzero)
    function automatic logic [4:0] clz24(input logic [23:0] v);
        logic [4:0] n;
        logic       found;
        n = 5'd0;
        found = 1'b0;
        for (int i = 23; i >= 0; i--) begin
            if (!found && v[i]) begin
                found = 1'b1;
                n = 5'(23 - i);
            end
        end
        return n;
    endfunction

    // Operand decode and special cases; product left for a register
    function automatic mul_mid_t mul_front(input logic [31:0] a, input logic [31:0] b,
                                           input logic [47:0] p);
        mul_mid_t   r;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [9:0]  ea;
        logic [9:0]  eb;
        logic [4:0]  za;
        logic [4:0]  zb;
        r = '0;
        ma = a & FP_ABS_MASK;
        mb = b & FP_ABS_MASK;
        r.sign = a[31] ^ b[31];
        za = clz24({ma[30:23] != 8'd0, ma[22:0]});
        zb = clz24({mb[30:23] != 8'd0, mb[22:0]});
        ea = (ma[30:23] == 8'd0) ? 10'd1 : {2'b00, ma[30:23]};
        eb = (mb[30:23] == 8'd0) ? 10'd1 : {2'b00, mb[30:23]};
        r.exp = ea - 10'(za) + eb - 10'(zb) - 10'd127;
        if (p[47]) begin
            r.exp = r.exp + 10'd1;
            r.prod = p;
        end else begin
            r.prod = {p[46:0], 1'b0};
        end
        if (ma > FP_INF) begin
            r.special = 1'b1;
            r.spec_val = a | FP_QUIET;
        end else if (mb > FP_INF) begin
            r.special = 1'b1;
            r.spec_val = b | FP_QUIET;
        end else if (ma == FP_INF || mb == FP_INF) begin
            r.special = 1'b1;
            r.spec_val = (ma == 32'd0 || mb == 32'd0) ? FP_QNAN : {r.sign, FP_INF[30:0]};
        end else if (ma == 32'd0 || mb == 32'd0) begin
            r.special = 1'b1;
            r.spec_val = {r.sign, 31'd0};
        end
        return r;
    endfunction

    // Normalized significands with leading one placed at bit 23
    function automatic logic [23:0] sig_norm(input logic [31:0] a);
        logic [23:0] s;
        s = {a[30:23] != 8'd0, a[22:0]};
        return s << clz24(s);
    endfunction

    // Round a normalized product to fp32, nearest-even, with subnormals
    function automatic logic [31:0] mul_round(input mul_mid_t m);
        logic [31:0] r;
        logic [5:0]  sh;
        logic [9:0]  shw;
        logic [47:0] keep;
        logic [47:0] rem;
        logic [47:0] half;
        logic [47:0] mask;
        logic [33:0] bits;
        sh = 6'd24;
        shw = 10'd24;
        if ($signed(m.exp) < 10'sd1) shw = 10'd25 - m.exp;
        if ($signed(m.exp) >= 10'sd255) begin
            r = {m.sign, FP_INF[30:0]};
        end else if (shw > 10'd48) begin
            r = {m.sign, 31'd0};
        end else begin
            sh = shw[5:0];
            keep = m.prod >> sh;
            mask = (48'd1 << sh) - 48'd1;
            rem = m.prod & mask;
            half = 48'd1 << (sh - 6'd1);
            if (rem > half || (rem == half && keep[0])) keep = keep + 48'd1;
            if ($signed(m.exp) < 10'sd1) bits = {10'd0, keep[23:0]};
            else bits = {m.exp[7:0] - 8'd1, 23'd0} + {9'd0, keep[24:0]};
            if (bits >= {2'b00, FP_INF}) r = {m.sign, FP_INF[30:0]};
            else r = {m.sign, bits[30:0]};
        end
        if (m.special) r = m.spec_val;
        return r;
    endfunction

    function automatic logic [15:0] to_bf16(input logic [31:0] v);
        logic [31:0] s;
        s = v + BF_BIAS + {31'd0, v[16]};
        if ((v & FP_ABS_MASK) > FP_INF) return v[31:16] | BF_QUIET;
        return s[31:16];
    endfunction
endpackage
`default_nettype wire

// File: src/nvdq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module nvdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        if (re) rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: src/nvdq_mul.sv
// Three-stage-per-multiply fp32 lane: code x scale, then x outer, then bf16.
// Depends on nvdq_pkg. Stall by en: all registers hold when en is low.
`default_nettype none
module nvdq_mul (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [31:0] code_val,
    input  wire logic [31:0] scale_val,
    input  wire logic [31:0] outer_val,
    output      logic [15:0] bf_val
);
    import nvdq_pkg::*;

    logic [31:0]   a1_reg, b1_reg, o1_reg;
    logic [47:0]   p1_reg;
    nvdq_pkg::mul_mid_t m1_reg;
    logic [31:0]   o2_reg;
    logic [31:0]   r1_reg;
    logic [31:0]   o3_reg;
    logic [31:0]   o3_reg_d;
    logic [47:0]   p2_reg;
    logic [31:0]   a2_reg;
    nvdq_pkg::mul_mid_t m2_reg;
    logic [31:0]   r2_reg;

    // Stage 1: first significand multiply
    // Stage 2: decode; Stage 3: round; Stage 4: second multiply
    // Stage 5: decode; Stage 6: round; Stage 7: bf16
    always_ff @(posedge aclk) begin
        if (en) begin
            a1_reg <= code_val;
            b1_reg <= scale_val;
            o1_reg <= outer_val;
            p1_reg <= 48'(sig_norm(code_val)) * 48'(sig_norm(scale_val));
            m1_reg <= mul_front(a1_reg, b1_reg, p1_reg);
            o2_reg <= o1_reg;
            r1_reg <= mul_round(m1_reg);
            o3_reg <= o2_reg;
            a2_reg <= {r1_reg[31], r1_reg[30:0]};
            p2_reg <= 48'(sig_norm(r1_reg)) * 48'(sig_norm(o3_reg));
            m2_reg <= mul_front(a2_reg, o3_reg_d, p2_reg);
            r2_reg <= mul_round(m2_reg);
            bf_val <= to_bf16(r2_reg);
        end
    end

    // Delay the outer scale to line up with the second decode
    always_ff @(posedge aclk) begin
        if (en) o3_reg_d <= o3_reg;
    end
endmodule
`default_nettype wire

// File: src/nvfp4_dequant_to_bf16.sv
// Top level of the NVFP4 to bfloat16 dequantizer: tables, valid pipeline,
// two multiply lanes. Depends on nvdq_pkg, nvdq_ram, nvdq_mul.
//
//  channel | ports                                   | role
//  s_      | cmd table_index table_value packed ...  | items in (convert/load)
//  m_      | first_value second_value                | one result per convert
//
// Path from accept to result: table read, two fp32 multipliers of three
// stages each, and the bf16 rounding stage. One item per cycle sustained
// unless the output stalls, as every stage is a plain register with no loop back.
// Synchronous active-low reset clears valid bits only; tables are undefined.
// Stall: pipeline advances only when its last stage is free or taken.
`default_nettype none
module nvfp4_dequant_to_bf16 (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output      logic        s_ready,
    input  wire logic [1:0]  s_cmd,
    input  wire logic [7:0]  s_table_index,
    input  wire logic [31:0] s_table_value,
    input  wire logic [7:0]  s_packed_codes,
    input  wire logic [7:0]  s_group_scale_code,
    input  wire logic [31:0] s_outer_scale,
    output      logic        m_valid,
    input  wire logic        m_ready,
    output      logic [15:0] m_first_value,
    output      logic [15:0] m_second_value
);
    import nvdq_pkg::*;

    localparam int DEPTH = 8;

    logic [DEPTH-1:0] vld_reg;
    logic             en;
    logic             conv;
    logic [31:0]      code0, code1, scale_q;
    logic [31:0]      outer_reg;

    assign en      = !vld_reg[DEPTH-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[DEPTH-1];
    assign conv    = s_valid && s_ready && (s_cmd == CMD_CONVERT);

    // Advance valid bits with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (en) vld_reg <= {vld_reg[DEPTH-2:0], conv};
    end

    // Hold the outer scale alongside the table reads
    always_ff @(posedge aclk) begin
        if (en) begin
            outer_reg <= s_outer_scale;
        end
    end

    // Code table read twice: two copies, both written on code loads
    nvdq_ram #(.WIDTH(32), .DEPTH(16)) u_code0 (
        .aclk(aclk), .we(s_valid && s_ready && s_cmd == CMD_LOAD_CODE),
        .waddr(s_table_index[3:0]), .wdata(s_table_value),
        .re(en), .raddr(s_packed_codes[3:0]), .rdata(code0));
    nvdq_ram #(.WIDTH(32), .DEPTH(16)) u_code1 (
        .aclk(aclk), .we(s_valid && s_ready && s_cmd == CMD_LOAD_CODE),
        .waddr(s_table_index[3:0]), .wdata(s_table_value),
        .re(en), .raddr(s_packed_codes[7:4]), .rdata(code1));
    nvdq_ram #(.WIDTH(32), .DEPTH(256)) u_scale (
        .aclk(aclk), .we(s_valid && s_ready && s_cmd == CMD_LOAD_SCALE),
        .waddr(s_table_index), .wdata(s_table_value),
        .re(en), .raddr(s_group_scale_code), .rdata(scale_q));

    // Two multiply lanes
    nvdq_mul u_lane0 (.aclk(aclk), .en(en), .code_val(code0), .scale_val(scale_q),
        .outer_val(outer_reg), .bf_val(m_first_value));
    nvdq_mul u_lane1 (.aclk(aclk), .en(en), .code_val(code1), .scale_val(scale_q),
        .outer_val(outer_reg), .bf_val(m_second_value));

    // Result holds while stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");
    assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg)) else $error("pipe moved in stall");
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_cmd != CMD_CONVERT |=> !vld_reg[0])
        else $error("load made a result");
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("ready mismatch");
endmodule
`default_nettype wire

// File: tb/sv/nvfp4_dequant_to_bf16_tb.sv
// Testbench for the NVFP4 to bfloat16 dequantizer: a queue-fed driver, a monitor and
// a bit-exact fp32/bf16 predictor. Depends on nvdq_pkg and nvfp4_dequant_to_bf16.
`timescale 1ns / 1ps
module nvfp4_dequant_to_bf16_tb;
    import nvdq_pkg::*;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  index;
        logic [31:0] value;
        logic [7:0]  codes;
        logic [7:0]  scode;
        logic [31:0] outer;
    } dq_item_t;

    typedef struct packed {
        logic [15:0] first;
        logic [15:0] second;
    } bf_pair_t;

    localparam int WATCHDOG_CYCLES = 20000;
    localparam int DRAIN_CYCLES    = 20;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_cmd;
    logic [7:0]  s_table_index;
    logic [31:0] s_table_value;
    logic [7:0]  s_packed_codes;
    logic [7:0]  s_group_scale_code;
    logic [31:0] s_outer_scale;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_first_value;
    logic [15:0] m_second_value;

    dq_item_t    pending_items[$];
    bf_pair_t    expected_pairs[$];
    logic [31:0] code_vals[16];
    logic [31:0] scale_vals[256];
    bit          code_written[16];
    bit          scale_written[256];
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_send;
    int          mismatches;
    int          idle_cycles;
    bit          timed_out;

    nvfp4_dequant_to_bf16 u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_table_index(s_table_index), .s_table_value(s_table_value),
        .s_packed_codes(s_packed_codes), .s_group_scale_code(s_group_scale_code),
        .s_outer_scale(s_outer_scale),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_first_value(m_first_value), .m_second_value(m_second_value)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // fp32 multiply, nearest-even with subnormals
    function automatic logic [31:0] fp32_product(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] sgn;
        logic [31:0] ma;
        logic [31:0] mb;
        int          ea;
        int          eb;
        int          e;
        int          shift;
        logic [23:0] fa;
        logic [23:0] fb;
        logic [63:0] p;
        logic [63:0] keep;
        logic [63:0] rem;
        logic [63:0] half;
        logic [63:0] bits;
        sgn = (a ^ b) & 32'h80000000;
        ma = a & FP_ABS_MASK;
        mb = b & FP_ABS_MASK;
        if (ma > FP_INF) return a | FP_QUIET;
        if (mb > FP_INF) return b | FP_QUIET;
        if (ma == FP_INF || mb == FP_INF) begin
            if (ma == 0 || mb == 0) return FP_QNAN;
            return sgn | FP_INF;
        end
        if (ma == 0 || mb == 0) return sgn;
        ea = ma[30:23];
        eb = mb[30:23];
        fa = {1'b0, ma[22:0]};
        fb = {1'b0, mb[22:0]};
        if (ea == 0) ea = 1; else fa[23] = 1'b1;
        if (eb == 0) eb = 1; else fb[23] = 1'b1;
        while (!fa[23]) begin fa = fa << 1; ea--; end
        while (!fb[23]) begin fb = fb << 1; eb--; end
        p = 64'(fa) * 64'(fb);
        e = ea + eb - 127;
        if (p[47]) e++; else p = p << 1;
        if (e >= 255) return sgn | FP_INF;
        shift = 24;
        if (e < 1) shift += 1 - e;
        if (shift > 48) begin
            keep = '0;
        end else begin
            keep = p >> shift;
            rem = p & ((64'd1 << shift) - 64'd1);
            half = 64'd1 << (shift - 1);
            if (rem > half || (rem == half && keep[0])) keep++;
        end
        if (e < 1) bits = keep;
        else bits = (64'(e - 1) << 23) + keep;
        if (bits >= 64'(FP_INF)) return sgn | FP_INF;
        return sgn | bits[31:0];
    endfunction

    function automatic logic [15:0] round_bf16(input logic [31:0] v);
        logic [31:0] s;
        if ((v & FP_ABS_MASK) > FP_INF) return v[31:16] | BF_QUIET;
        s = v + 32'h7fff + {31'd0, v[16]};
        return s[31:16];
    endfunction

    function automatic logic [15:0] dequant_element(input logic [3:0] code,
                                                    input logic [31:0] scale,
                                                    input logic [31:0] outer);
        return round_bf16(fp32_product(fp32_product(code_vals[code], scale), outer));
    endfunction

    // Interesting fp32 patterns for table values and outer scales
    function automatic logic [31:0] pick_fp32();
        case ($urandom_range(0, 11))
            0: return {$urandom_range(0, 1) == 1, 31'd0};
            1: return {$urandom_range(0, 1) == 1, FP_INF[30:0]};
            2: return {$urandom_range(0, 1) == 1, 8'hff, 23'($urandom_range(1, 32'h7fffff))};
            3: return {$urandom_range(0, 1) == 1, 8'h00, 23'($urandom())};
            4: return {$urandom_range(0, 1) == 1, 8'($urandom_range(200, 254)), 23'($urandom())};
            5: return {$urandom_range(0, 1) == 1, 8'($urandom_range(1, 40)), 23'($urandom())};
            6: return {$urandom_range(0, 1) == 1, 8'hfe, 23'h7fffff};
            default: return {$urandom_range(0, 1) == 1, 8'($urandom_range(100, 150)),
                             23'($urandom())};
        endcase
    endfunction

    function automatic dq_item_t load_item(input logic [1:0] cmd, input logic [7:0] index,
                                           input logic [31:0] value);
        dq_item_t it;
        it = '0;
        it.cmd = cmd;
        it.index = index;
        it.value = value;
        it.codes = 8'($urandom());
        it.scode = 8'($urandom());
        it.outer = $urandom();
        return it;
    endfunction

    // Convert item touching only written entries
    function automatic dq_item_t convert_item(input logic [31:0] outer);
        dq_item_t it;
        logic [3:0] lo;
        logic [3:0] hi;
        logic [7:0] sc;
        it = '0;
        it.cmd = CMD_CONVERT;
        do lo = 4'($urandom()); while (!code_written[lo]);
        do hi = 4'($urandom()); while (!code_written[hi]);
        do sc = 8'($urandom()); while (!scale_written[sc]);
        it.codes = {hi, lo};
        it.scode = sc;
        it.index = 8'($urandom());
        it.value = $urandom();
        it.outer = outer;
        return it;
    endfunction

    // Queue an item, tracking which entries it makes readable
    task automatic queue_item(input dq_item_t it);
        if (it.cmd == CMD_LOAD_CODE) code_written[it.index[3:0]] = 1'b1;
        if (it.cmd == CMD_LOAD_SCALE) scale_written[it.index] = 1'b1;
        pending_items.push_back(it);
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || expected_pairs.size() != 0 || s_valid)
            @(posedge aclk);
    endtask

    // Driver: present the next pending item, hold until accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_items.size() != 0 && !hold_send &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                dq_item_t it;
                it = pending_items.pop_front();
                s_valid <= 1'b1;
                s_cmd <= it.cmd;
                s_table_index <= it.index;
                s_table_value <= it.value;
                s_packed_codes <= it.codes;
                s_group_scale_code <= it.scode;
                s_outer_scale <= it.outer;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Predict on accept: update tables or push the expected pair
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            case (s_cmd)
                CMD_LOAD_CODE:  code_vals[s_table_index[3:0]] = s_table_value;
                CMD_LOAD_SCALE: scale_vals[s_table_index] = s_table_value;
                CMD_CONVERT: begin
                    bf_pair_t pr;
                    pr.first = dequant_element(s_packed_codes[3:0],
                                               scale_vals[s_group_scale_code], s_outer_scale);
                    pr.second = dequant_element(s_packed_codes[7:4],
                                                scale_vals[s_group_scale_code], s_outer_scale);
                    expected_pairs.push_back(pr);
                end
                default: ;
            endcase
        end
    end

    // Monitor: compare each result with the oldest expectation; drive stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_pairs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h %h", m_first_value, m_second_value);
                end else begin
                    bf_pair_t pr;
                    pr = expected_pairs.pop_front();
                    if (pr.first !== m_first_value || pr.second !== m_second_value) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %h %h, got %h %h",
                                     pr.first, pr.second, m_first_value, m_second_value);
                    end
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog on cycles without any accept
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_CYCLES) begin
            timed_out = 1'b1;
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Random phase: mostly converts with occasional table reloads and unused commands
    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++) begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 8) queue_item(load_item(CMD_LOAD_CODE, 8'($urandom()), pick_fp32()));
            else if (r < 16) queue_item(load_item(CMD_LOAD_SCALE, 8'($urandom()), pick_fp32()));
            else if (r < 19) queue_item(load_item(CMD_UNUSED, 8'($urandom()), $urandom()));
            else queue_item(convert_item(($urandom_range(0, 3) == 0) ? $urandom() : pick_fp32()));
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        m_ready = 1'b0;
        s_cmd = '0;
        s_table_index = '0;
        s_table_value = '0;
        s_packed_codes = '0;
        s_group_scale_code = '0;
        s_outer_scale = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_send = 1'b0;
        mismatches = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: fill the code table with signed zeros and powers of two, edge scales
        for (int c = 0; c < 16; c++) begin
            logic [31:0] v;
            v = {c[3], 8'(c[2:0] == 0 ? 0 : 126 + c[2:0]), 23'd0};
            queue_item(load_item(CMD_LOAD_CODE, 8'(c), v));
        end
        queue_item(load_item(CMD_LOAD_SCALE, 8'h00, 32'h3f800000));
        queue_item(load_item(CMD_LOAD_SCALE, 8'hff, 32'h7f7fffff));
        queue_item(load_item(CMD_LOAD_SCALE, 8'h01, 32'h00000001));
        queue_item(load_item(CMD_LOAD_SCALE, 8'h02, 32'h7fa00000));
        queue_item(load_item(CMD_UNUSED, 8'hff, 32'hffffffff));
        begin
            dq_item_t it;
            it = convert_item(32'h3f800000); it.codes = 8'hf0; it.scode = 8'h00;
            queue_item(it);
            it.scode = 8'hff; it.outer = 32'h7f7fffff;             // overflow
            queue_item(it);
            it.scode = 8'h01; it.outer = 32'h3e000000;             // underflow
            queue_item(it);
            it.scode = 8'h02; it.outer = 32'hffc12345;             // NaN scale
            queue_item(it);
            it.scode = 8'h00; it.codes = 8'h80; it.outer = 32'h7f800000; // inf * zero
            queue_item(it);
            it.outer = 32'hffffffff;
            queue_item(it);
        end
        wait_drained();

        // Phases with different idling; pause for drain between them
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? 79 : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? 79 : 0;
            if (ph == 3) begin send_idle_pct = 15; recv_stall_pct = 15; end
            random_phase(ph == 0 ? 500 : 310);
            wait_drained();
            hold_send = 1'b1;
            repeat (DRAIN_CYCLES) @(posedge aclk);
            hold_send = 1'b0;
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_pairs.size() == 0 && !timed_out) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// File: filelist.f
src/nvdq_pkg.sv
src/nvdq_ram.sv
src/nvdq_mul.sv
src/nvfp4_dequant_to_bf16.sv
tb/sv/nvfp4_dequant_to_bf16_tb.sv
